### design/vrt_pkg.sv
// Shared constants, types and codes for the voxel ray traversal engine.
package vrt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CELL_BITS = 16;

    localparam int ORG_W  = 32;
    localparam int DIR_W  = 18;
    localparam int T_W    = 32;
    localparam int LIM_W  = 31;
    localparam int QW     = 2 * FRAC_BITS + 1;
    localparam int MB_W   = (FRAC_BITS + 2 > DIR_W) ? FRAC_BITS + 2 : DIR_W;
    localparam int PW     = T_W + 1 + MB_W;
    localparam int SW     = PW - FRAC_BITS;
    localparam int CNT_W  = $clog2(QW);

    localparam logic [T_W-1:0] T_INF = 32'hFFFF_FFFF;
    localparam logic [T_W-1:0] T_SAT = 32'hFFFF_FFFE;
    localparam logic [1:0]     NO_AXIS = 2'd3;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_ANSWER = 2'd1,
        OP_RESUME = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        K_LOOKUP   = 3'd0,
        K_HIT      = 3'd1,
        K_BOX      = 3'd2,
        K_MISS     = 3'd3,
        K_UNLOADED = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LOOKUP = 2'd1,
        PH_BOX    = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_CMUL,
        S_CSAT,
        S_ADV,
        S_EMUL,
        S_EADD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### design/vrt_div.sv
// Bit-serial restoring divider: 2^(2F) divided by a direction magnitude, saturated.
module vrt_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [vrt_pkg::DIR_W-1:0] i_den,
    output vrt_pkg::t_div_stat        o_stat,
    output logic [vrt_pkg::T_W-1:0]   o_quot
);
    import vrt_pkg::*;

    logic [DIR_W-1:0] r_rem;
    logic [DIR_W-1:0] r_den;
    logic [QW-1:0]    r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIR_W:0]   trial;
    logic             num_bit;

    // dividend is a single one at the top bit, zeros below
    assign num_bit = (r_cnt == CNT_W'(QW - 1));
    assign trial   = {r_rem, num_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QW - 1);
                r_rem  <= '0;
                r_quot <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_den}) begin
                    r_rem  <= DIR_W'(trial - {1'b0, r_den});
                    r_quot <= {r_quot[QW-2:0], 1'b1};
                end else begin
                    r_rem  <= trial[DIR_W-1:0];
                    r_quot <= {r_quot[QW-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot = (r_quot > QW'(T_SAT)) ? T_SAT : r_quot[T_W-1:0];

endmodule

### design/voxel_ray_traversal.sv
// Top level of the voxel ray traversal engine: sequencer, shared multiplier, walk state.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+------------------------------------------
//  input   | i_in_valid   | o_in_stall   | i_op, origin, dir, max_dist, cell flags
//  output  | o_out_valid  | i_out_stall  | o_kind, cell, end, normal, distance
//
// A start runs the divider once per moving axis, for QW = 2*FRAC_BITS+1 quotient bits.
// A lookup answer or resume that steps passes through S_ADV first; other answers do not.
// The end point uses the single multiplier once per axis, in S_EMUL then S_EADD.
// Reset clears the sequencer, walk phase and divider status only. o_in_stall is high until the
// result transaction completes; an ignored op produces no result.
module voxel_ray_traversal (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_op,
    input  logic signed [vrt_pkg::ORG_W-1:0]  i_origin_x,
    input  logic signed [vrt_pkg::ORG_W-1:0]  i_origin_y,
    input  logic signed [vrt_pkg::ORG_W-1:0]  i_origin_z,
    input  logic signed [vrt_pkg::DIR_W-1:0]  i_dir_x,
    input  logic signed [vrt_pkg::DIR_W-1:0]  i_dir_y,
    input  logic signed [vrt_pkg::DIR_W-1:0]  i_dir_z,
    input  logic [vrt_pkg::LIM_W-1:0]         i_max_dist,
    input  logic                              i_cell_loaded,
    input  logic                              i_cell_selectable,
    input  logic                              i_cell_solid,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_kind,
    output logic signed [15:0]                o_cell_x,
    output logic signed [15:0]                o_cell_y,
    output logic signed [15:0]                o_cell_z,
    output logic signed [31:0]                o_end_x,
    output logic signed [31:0]                o_end_y,
    output logic signed [31:0]                o_end_z,
    output logic signed [1:0]                 o_normal_x,
    output logic signed [1:0]                 o_normal_y,
    output logic signed [1:0]                 o_normal_z,
    output logic [30:0]                       o_distance
);
    import vrt_pkg::*;

    localparam logic signed [SW:0] E_MAX = (SW+1)'(32'sh7FFF_FFFF);
    localparam logic signed [SW:0] E_MIN = (SW+1)'(-33'sd2147483648);

    t_state r_state, n_state;
    t_phase r_phase;
    t_kind  r_kind;

    logic signed [ORG_W-1:0] r_origin [3];
    logic signed [DIR_W-1:0] r_dir    [3];
    logic [CELL_BITS-1:0]    r_cell   [3];
    logic                    r_neg    [3];
    logic [T_W-1:0]          r_delta  [3];
    logic [T_W-1:0]          r_cross  [3];
    logic signed [31:0]      r_end    [3];
    logic [LIM_W-1:0]        r_limit;
    logic [T_W-1:0]          r_t;
    logic [1:0]              r_last;
    logic [1:0]              r_ax;
    logic signed [PW-1:0]    r_prod;

    function automatic logic [T_W-1:0] add_cross(input logic [T_W-1:0] a,
                                                 input logic [T_W-1:0] b);
        logic [T_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (a == T_INF || b == T_INF)
            return T_INF;
        return (s > {1'b0, T_SAT}) ? T_SAT : s[T_W-1:0];
    endfunction

    function automatic logic [15:0] cell_out(input logic [CELL_BITS-1:0] c);
        logic signed [31:0] e;
        e = 32'(signed'(c));
        return e[15:0];
    endfunction

    // input decode
    logic accept, do_start, do_answer, do_resume;
    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign do_start  = accept && (i_op == OP_START);
    assign do_answer = accept && (i_op == OP_ANSWER) && (r_phase == PH_LOOKUP);
    assign do_resume = accept && (i_op == OP_RESUME) && (r_phase == PH_BOX);

    // divider
    t_div_stat        div_stat;
    logic [T_W-1:0]   div_quot;
    logic             div_start;
    logic [DIR_W-1:0] dir_mag;
    logic             dir_zero;

    assign dir_zero  = (r_dir[r_ax] == '0);
    assign dir_mag   = r_dir[r_ax][DIR_W-1] ? DIR_W'(-r_dir[r_ax]) : DIR_W'(r_dir[r_ax]);
    assign div_start = (r_state == S_SETUP) && !dir_zero;

    vrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_den   (dir_mag),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // shared multiplier: crossing setup or end point
    logic [FRAC_BITS:0]   frac_dist;
    logic signed [T_W:0]  mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [PW-1:0] mul_p;

    assign frac_dist = r_neg[r_ax] ? {1'b0, r_origin[r_ax][FRAC_BITS-1:0]}
                                   : (FRAC_BITS+1)'(1 << FRAC_BITS)
                                     - {1'b0, r_origin[r_ax][FRAC_BITS-1:0]};
    always_comb begin
        if (r_state == S_CMUL) begin
            mul_a = {1'b0, r_delta[r_ax]};
            mul_b = MB_W'(frac_dist);
        end else begin
            mul_a = {1'b0, r_t};
            mul_b = MB_W'(r_dir[r_ax]);
        end
    end
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    logic [SW-1:0]        prod_hi;
    logic [T_W-1:0]       cross_sat;
    logic signed [SW-1:0] q_end;
    logic signed [SW:0]   sum_end;
    logic signed [31:0]   end_sat;

    assign prod_hi   = r_prod[PW-1:FRAC_BITS];
    assign cross_sat = (prod_hi > SW'(T_SAT)) ? T_SAT : prod_hi[T_W-1:0];
    assign q_end     = prod_hi;
    assign sum_end   = (SW+1)'(q_end) + (SW+1)'(r_origin[r_ax]);
    always_comb begin
        if (sum_end > E_MAX)
            end_sat = 32'sh7FFF_FFFF;
        else if (sum_end < E_MIN)
            end_sat = -32'sd2147483648;
        else
            end_sat = sum_end[31:0];
    end

    // step axis choice, ties go to the later axis
    logic [1:0]     adv_ax;
    logic [T_W-1:0] adv_t;
    always_comb begin
        if (r_cross[0] < r_cross[1])
            adv_ax = (r_cross[0] < r_cross[2]) ? 2'd0 : 2'd2;
        else
            adv_ax = (r_cross[1] < r_cross[2]) ? 2'd1 : 2'd2;
    end
    assign adv_t = r_cross[adv_ax];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (do_start)
                    n_state = S_SETUP;
                else if (do_answer)
                    n_state = (i_cell_loaded && !i_cell_selectable) ? S_ADV : S_EMUL;
                else if (do_resume)
                    n_state = S_ADV;
            end
            S_SETUP: begin
                if (!dir_zero)
                    n_state = S_DIV;
                else if (r_ax == 2'd2)
                    n_state = S_EMUL;
            end
            S_DIV:  if (div_stat.done) n_state = S_CMUL;
            S_CMUL: n_state = S_CSAT;
            S_CSAT: n_state = (r_ax == 2'd2) ? S_EMUL : S_SETUP;
            S_ADV:  n_state = S_EMUL;
            S_EMUL: n_state = S_EADD;
            S_EADD: n_state = (r_ax == 2'd2) ? S_OUT : S_EMUL;
            S_OUT:  if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (do_start) begin
                        r_origin[0] <= i_origin_x;
                        r_origin[1] <= i_origin_y;
                        r_origin[2] <= i_origin_z;
                        r_dir[0]    <= i_dir_x;
                        r_dir[1]    <= i_dir_y;
                        r_dir[2]    <= i_dir_z;
                        r_cell[0]   <= CELL_BITS'(i_origin_x >>> FRAC_BITS);
                        r_cell[1]   <= CELL_BITS'(i_origin_y >>> FRAC_BITS);
                        r_cell[2]   <= CELL_BITS'(i_origin_z >>> FRAC_BITS);
                        r_neg[0]    <= !(i_dir_x > 0);
                        r_neg[1]    <= !(i_dir_y > 0);
                        r_neg[2]    <= !(i_dir_z > 0);
                        r_limit     <= i_max_dist;
                        r_t         <= '0;
                        r_last      <= NO_AXIS;
                        r_phase     <= PH_LOOKUP;
                        r_kind      <= K_LOOKUP;
                        r_ax        <= 2'd0;
                    end else if (do_answer) begin
                        r_ax <= 2'd0;
                        if (!i_cell_loaded) begin
                            r_phase <= PH_IDLE;
                            r_kind  <= K_UNLOADED;
                        end else if (i_cell_selectable && i_cell_solid) begin
                            r_phase <= PH_IDLE;
                            r_kind  <= K_HIT;
                        end else if (i_cell_selectable) begin
                            r_phase <= PH_BOX;
                            r_kind  <= K_BOX;
                        end
                    end
                end
                S_SETUP: begin
                    if (dir_zero) begin
                        r_delta[r_ax] <= T_INF;
                        r_cross[r_ax] <= T_INF;
                        r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    end
                end
                S_DIV:  if (div_stat.done) r_delta[r_ax] <= div_quot;
                S_CMUL: r_prod <= mul_p;
                S_CSAT: begin
                    r_cross[r_ax] <= cross_sat;
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                end
                S_ADV: begin
                    r_cell[adv_ax]  <= r_neg[adv_ax] ? r_cell[adv_ax] - 1'b1
                                                     : r_cell[adv_ax] + 1'b1;
                    r_t             <= adv_t;
                    r_cross[adv_ax] <= add_cross(adv_t, r_delta[adv_ax]);
                    r_last          <= adv_ax;
                    r_ax            <= 2'd0;
                    if (adv_t <= {1'b0, r_limit}) begin
                        r_phase <= PH_LOOKUP;
                        r_kind  <= K_LOOKUP;
                    end else begin
                        r_phase <= PH_IDLE;
                        r_kind  <= K_MISS;
                    end
                end
                S_EMUL: r_prod <= mul_p;
                S_EADD: begin
                    r_end[r_ax] <= end_sat;
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // outputs held in registers until the result transaction completes
    logic hit;
    assign hit = (r_kind == K_HIT);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_kind      = r_kind;
    assign o_cell_x    = cell_out(r_cell[0]);
    assign o_cell_y    = cell_out(r_cell[1]);
    assign o_cell_z    = cell_out(r_cell[2]);
    assign o_end_x     = r_end[0];
    assign o_end_y     = r_end[1];
    assign o_end_z     = r_end[2];
    assign o_normal_x  = (hit && r_last == 2'd0) ? (r_neg[0] ? 2'sd1 : -2'sd1) : 2'sd0;
    assign o_normal_y  = (hit && r_last == 2'd1) ? (r_neg[1] ? 2'sd1 : -2'sd1) : 2'sd0;
    assign o_normal_z  = (hit && r_last == 2'd2) ? (r_neg[2] ? 2'sd1 : -2'sd1) : 2'sd0;
    assign o_distance  = r_t[31] ? 31'h7FFF_FFFF : r_t[30:0];

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == S_DIV))
        else $error("divider running outside its sequencer step");

    a_end_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_kind == K_HIT || r_kind == K_MISS || r_kind == K_UNLOADED))
        |-> (r_phase == PH_IDLE))
        else $error("walk still live after a final result");

    a_box_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_kind == K_BOX) |-> (r_phase == PH_BOX))
        else $error("box result without box phase");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(r_t) && $stable(r_kind)))
        else $error("stalled result changed");

endmodule
